/* rtl/core/bpdc_pkg.sv */
// ----------------------------------------------------------------------------
// bpdc_pkg
// Shared types and constants for the button press duration classifier.
// ----------------------------------------------------------------------------
package bpdc_pkg;

   // Field widths
   localparam int unsigned INDEX_W = 3;
   localparam int unsigned TICK_W  = 32;
   localparam int unsigned MASK_W  = 8;
   localparam int unsigned LIMIT_W = 16;
   localparam int unsigned KEY_W   = 2;
   localparam int unsigned CSR_W   = 16;

   // Register indexes
   localparam logic [2:0] CSR_ENABLE_MASK  = 3'd0;
   localparam logic [2:0] CSR_SWITCH_MASK  = 3'd1;
   localparam logic [2:0] CSR_INVERT_MASK  = 3'd2;
   localparam logic [2:0] CSR_SHORT_LIMIT  = 3'd3;
   localparam logic [2:0] CSR_MEDIUM_LIMIT = 3'd4;
   localparam logic [2:0] CSR_LOCK_LIMIT   = 3'd5;

   // Register reset values
   localparam logic [MASK_W-1:0]  RST_ENABLE_MASK  = 8'd1;
   localparam logic [MASK_W-1:0]  RST_SWITCH_MASK  = 8'd0;
   localparam logic [MASK_W-1:0]  RST_INVERT_MASK  = 8'd255;
   localparam logic [LIMIT_W-1:0] RST_SHORT_LIMIT  = 16'd100;
   localparam logic [LIMIT_W-1:0] RST_MEDIUM_LIMIT = 16'd300;
   localparam logic [LIMIT_W-1:0] RST_LOCK_LIMIT   = 16'd310;

   // Key codes
   localparam logic [KEY_W-1:0] KEY_SHORT  = 2'd0;
   localparam logic [KEY_W-1:0] KEY_MEDIUM = 2'd1;
   localparam logic [KEY_W-1:0] KEY_LONG   = 2'd2;

   // Per-button state entry
   typedef struct packed {
      logic              level;
      logic              lock;
      logic [TICK_W-1:0] start;
   } btn_state_type;

   // Result of one classification pass
   typedef struct packed {
      logic               fire;
      logic [KEY_W-1:0]   key;
      logic [TICK_W-1:0]  held;
      logic               from_switch;
   } event_type;

endpackage

/* rtl/core/button_press_duration_classifier.sv */
// ----------------------------------------------------------------------------
// button_press_duration_classifier
// Classifies per-button samples into switch, short, medium and long events.
// ----------------------------------------------------------------------------
// Pipeline: req transfer into the input register, then the result register, which
// drives rsp valid; state is updated in the same cycle as the result register.
// Throughput: one sample per cycle while the event channel is not stalled.
// Reset: synchronous; registers return to their defaults, all buttons
// released and unlocked, pipeline empty.
module button_press_duration_classifier #(
   parameter int unsigned NUM_BUTTONS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // sample channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bpdc_pkg::INDEX_W-1:0]  req_button_index,
   input  logic                          req_raw_level,
   input  logic [bpdc_pkg::TICK_W-1:0]   req_now_ticks,
   // event channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bpdc_pkg::INDEX_W-1:0]  rsp_event_button,
   output logic [bpdc_pkg::KEY_W-1:0]    rsp_key_index,
   output logic [bpdc_pkg::TICK_W-1:0]   rsp_held_ticks,
   output logic                          rsp_from_switch,
   // configuration
   input  logic                          csr_write_en,
   input  logic [2:0]                    csr_index,
   input  logic [bpdc_pkg::CSR_W-1:0]    csr_wdata
);

   // Configuration registers
   logic [bpdc_pkg::MASK_W-1:0]  enable_mask_ff;
   logic [bpdc_pkg::MASK_W-1:0]  switch_mask_ff;
   logic [bpdc_pkg::MASK_W-1:0]  invert_mask_ff;
   logic [bpdc_pkg::LIMIT_W-1:0] short_limit_ff;
   logic [bpdc_pkg::LIMIT_W-1:0] medium_limit_ff;
   logic [bpdc_pkg::LIMIT_W-1:0] lock_limit_ff;

   // Input register
   logic                         in_valid_ff;
   logic [bpdc_pkg::INDEX_W-1:0] in_index_ff;
   logic                         in_level_ff;
   logic [bpdc_pkg::TICK_W-1:0]  in_now_ff;

   // Result register
   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic [bpdc_pkg::INDEX_W-1:0] out_button_ff;
   logic [bpdc_pkg::KEY_W-1:0]   out_key_ff;
   logic [bpdc_pkg::TICK_W-1:0]  out_held_ff;
   logic                         out_switch_ff;

   logic                         advance;
   logic                         active;
   logic                         level;
   logic                         st_wr_en;
   bpdc_pkg::btn_state_type      st_cur;
   bpdc_pkg::btn_state_type      st_nxt;
   bpdc_pkg::event_type          evt;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff  <= bpdc_pkg::RST_ENABLE_MASK;
         switch_mask_ff  <= bpdc_pkg::RST_SWITCH_MASK;
         invert_mask_ff  <= bpdc_pkg::RST_INVERT_MASK;
         short_limit_ff  <= bpdc_pkg::RST_SHORT_LIMIT;
         medium_limit_ff <= bpdc_pkg::RST_MEDIUM_LIMIT;
         lock_limit_ff   <= bpdc_pkg::RST_LOCK_LIMIT;
      end else if (csr_write_en) begin
         case (csr_index)
            bpdc_pkg::CSR_ENABLE_MASK:  enable_mask_ff  <= csr_wdata[bpdc_pkg::MASK_W-1:0];
            bpdc_pkg::CSR_SWITCH_MASK:  switch_mask_ff  <= csr_wdata[bpdc_pkg::MASK_W-1:0];
            bpdc_pkg::CSR_INVERT_MASK:  invert_mask_ff  <= csr_wdata[bpdc_pkg::MASK_W-1:0];
            bpdc_pkg::CSR_SHORT_LIMIT:  short_limit_ff  <= csr_wdata;
            bpdc_pkg::CSR_MEDIUM_LIMIT: medium_limit_ff <= csr_wdata;
            bpdc_pkg::CSR_LOCK_LIMIT:   lock_limit_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake: stage 1 moves on whenever the result slot is free or draining
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_index_ff <= req_button_index;
         in_level_ff <= req_raw_level;
         in_now_ff   <= req_now_ticks;
      end
   end

   // Sample qualification and polarity
   assign active = advance
                 & ({1'b0, in_index_ff} < (bpdc_pkg::INDEX_W + 1)'(NUM_BUTTONS))
                 & enable_mask_ff[in_index_ff];
   assign level  = in_level_ff ^ invert_mask_ff[in_index_ff];

   bpdc_state #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_state (
      .clock    (clock),
      .reset    (reset),
      .rd_index (in_index_ff),
      .rd_entry (st_cur),
      .wr_en    (st_wr_en),
      .wr_index (in_index_ff),
      .wr_entry (st_nxt)
   );

   bpdc_classify u_classify (
      .active       (active),
      .level        (level),
      .is_switch    (switch_mask_ff[in_index_ff]),
      .now_ticks    (in_now_ff),
      .short_limit  (short_limit_ff),
      .medium_limit (medium_limit_ff),
      .lock_limit   (lock_limit_ff),
      .cur          (st_cur),
      .nxt          (st_nxt),
      .wr_en        (st_wr_en),
      .evt          (evt)
   );

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = evt.fire;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && evt.fire) begin
         out_button_ff <= in_index_ff;
         out_key_ff    <= evt.key;
         out_held_ff   <= evt.held;
         out_switch_ff <= evt.from_switch;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_button = out_button_ff;
   assign rsp_key_index    = out_key_ff;
   assign rsp_held_ticks   = out_held_ff;
   assign rsp_from_switch  = out_switch_ff;

endmodule

/* rtl/core/bpdc_state.sv */
// ----------------------------------------------------------------------------
// bpdc_state
// Per-button state registers: one read port and one write port.
// ----------------------------------------------------------------------------
module bpdc_state #(
   parameter int unsigned NUM_BUTTONS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [bpdc_pkg::INDEX_W-1:0] rd_index,
   output bpdc_pkg::btn_state_type     rd_entry,
   input  logic                        wr_en,
   input  logic [bpdc_pkg::INDEX_W-1:0] wr_index,
   input  bpdc_pkg::btn_state_type     wr_entry
);

   localparam int unsigned IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

   bpdc_pkg::btn_state_type entry_ff [NUM_BUTTONS];

   // Read mux; caller gates out-of-range indexes
   assign rd_entry = entry_ff[rd_index[IDX_W-1:0]];

   // Entry update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            entry_ff[b] <= '0;
         end
      end else if (wr_en) begin
         entry_ff[wr_index[IDX_W-1:0]] <= wr_entry;
      end
   end

endmodule

/* rtl/core/bpdc_classify.sv */
// ----------------------------------------------------------------------------
// bpdc_classify
// Combinational update of one button sample: edge detect, hold timing,
// lock handling and key selection.
// ----------------------------------------------------------------------------
module bpdc_classify (
   input  logic                          active,
   input  logic                          level,
   input  logic                          is_switch,
   input  logic [bpdc_pkg::TICK_W-1:0]   now_ticks,
   input  logic [bpdc_pkg::LIMIT_W-1:0]  short_limit,
   input  logic [bpdc_pkg::LIMIT_W-1:0]  medium_limit,
   input  logic [bpdc_pkg::LIMIT_W-1:0]  lock_limit,
   input  bpdc_pkg::btn_state_type       cur,
   output bpdc_pkg::btn_state_type       nxt,
   output logic                          wr_en,
   output bpdc_pkg::event_type           evt
);

   logic                        lock_c;
   logic                        press;
   logic [bpdc_pkg::TICK_W-1:0] start_c;
   logic [bpdc_pkg::TICK_W-1:0] held;
   logic [bpdc_pkg::KEY_W-1:0]  key;
   logic                        over_lock;

   // Hold time and key from the limits
   always_comb begin
      lock_c    = level & cur.lock;
      press     = level & ~cur.level;
      start_c   = press ? now_ticks : cur.start;
      held      = now_ticks - start_c;
      over_lock = held > {{(bpdc_pkg::TICK_W-bpdc_pkg::LIMIT_W){1'b0}}, lock_limit};
      if (held < {{(bpdc_pkg::TICK_W-bpdc_pkg::LIMIT_W){1'b0}}, short_limit}) begin
         key = bpdc_pkg::KEY_SHORT;
      end else if (held < {{(bpdc_pkg::TICK_W-bpdc_pkg::LIMIT_W){1'b0}}, medium_limit}) begin
         key = bpdc_pkg::KEY_MEDIUM;
      end else begin
         key = bpdc_pkg::KEY_LONG;
      end
   end

   // Next state and event
   always_comb begin
      nxt   = cur;
      wr_en = active;
      evt   = '0;
      if (is_switch) begin
         // level switch: fire on any change
         nxt.level       = level;
         evt.fire        = active & (level != cur.level);
         evt.key         = {1'b0, level};
         evt.from_switch = 1'b1;
      end else if (lock_c) begin
         // locked and still pressed: nothing changes
         wr_en = 1'b0;
      end else if (!level) begin
         // release: fire if it was pressed
         nxt.level = 1'b0;
         nxt.lock  = 1'b0;
         evt.fire  = active & cur.level;
         evt.key   = key;
         evt.held  = held;
      end else begin
         // pressed: stamp on edge, fire and lock past the lock limit
         nxt.start = start_c;
         nxt.level = ~over_lock;
         nxt.lock  = over_lock;
         evt.fire  = active & over_lock;
         evt.key   = key;
         evt.held  = held;
      end
   end

endmodule
